@@ hdl/srm_pkg.sv @@
// shared types, constants and helpers of the source rate monitor
package srm_pkg;

	localparam int DEF_COUNT_SLOTS = 16;
	localparam int DEF_BAN_SLOTS   = 16;
	localparam int MAX_VIOL        = 16;
	localparam int VCW             = $clog2(MAX_VIOL + 1);
	localparam int VIW             = $clog2(MAX_VIOL);
	localparam logic [31:0] WINDOW_MS = 32'd1000;
	localparam logic [15:0] CNT_MAX   = 16'hFFFF;
	localparam int AW = 6;
	localparam int DW = 64;

	typedef enum logic [2:0] {
		REG_ENABLED      = 3'd0,
		REG_WINDOW_LIMIT = 3'd1,
		REG_SOURCE_LIMIT = 3'd2,
		REG_AUTO_BAN     = 3'd3,
		REG_LIFETIME     = 3'd4,
		REG_DENY_ALL     = 3'd5,
		REG_ALLOW_NET    = 3'd6,
		REG_BLOCK_NET    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] window_packet_limit;
		logic [15:0] source_limit;
		logic        auto_ban;
		logic [15:0] ban_lifetime_s;
		logic        deny_all;
		logic [37:0] allow_network;
		logic [37:0] block_network;
	} cfg_t;

	typedef struct packed {
		logic        func;
		logic [31:0] source_addr;
	} req_t;

	typedef struct packed {
		logic        banned;
		logic        threshold_violated;
		logic        violator_valid;
		logic [31:0] violator_addr;
		logic        table_full;
		logic        last;
	} rsp_t;

	// prefix match, prefix lengths above 32 act as 32
	function automatic logic net_match(input logic [37:0] net, input logic [31:0] a);
		logic [5:0]  plen;
		logic [31:0] mask;
		plen = net[5:0];
		if (plen >= 6'd32)
			mask = 32'hFFFF_FFFF;
		else
			mask = ~(32'hFFFF_FFFF >> plen);
		return (plen != 6'd0) && (((a ^ net[37:6]) & mask) == 32'd0);
	endfunction

endpackage

@@ hdl/srm_regs.sv @@
// configuration register file behind the apb port
module srm_regs import srm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [DW-1:0] pwdata,
	output logic [DW-1:0] prdata,
	output logic          pready,
	output cfg_t          cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[AW-1:3]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled             <= 1'b0;
			cfg_q.window_packet_limit <= 16'd100;
			cfg_q.source_limit        <= 16'd50;
			cfg_q.auto_ban            <= 1'b1;
			cfg_q.ban_lifetime_s      <= 16'd0;
			cfg_q.deny_all            <= 1'b0;
			cfg_q.allow_network       <= 38'd0;
			cfg_q.block_network       <= 38'd0;
		end else if (wr) begin
			unique case (idx)
				REG_ENABLED:      cfg_q.enabled             <= pwdata[0];
				REG_WINDOW_LIMIT: cfg_q.window_packet_limit <= pwdata[15:0];
				REG_SOURCE_LIMIT: cfg_q.source_limit        <= pwdata[15:0];
				REG_AUTO_BAN:     cfg_q.auto_ban            <= pwdata[0];
				REG_LIFETIME:     cfg_q.ban_lifetime_s      <= pwdata[15:0];
				REG_DENY_ALL:     cfg_q.deny_all            <= pwdata[0];
				REG_ALLOW_NET:    cfg_q.allow_network       <= pwdata[37:0];
				REG_BLOCK_NET:    cfg_q.block_network       <= pwdata[37:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_ENABLED:      prdata = DW'(cfg_q.enabled);
			REG_WINDOW_LIMIT: prdata = DW'(cfg_q.window_packet_limit);
			REG_SOURCE_LIMIT: prdata = DW'(cfg_q.source_limit);
			REG_AUTO_BAN:     prdata = DW'(cfg_q.auto_ban);
			REG_LIFETIME:     prdata = DW'(cfg_q.ban_lifetime_s);
			REG_DENY_ALL:     prdata = DW'(cfg_q.deny_all);
			REG_ALLOW_NET:    prdata = DW'(cfg_q.allow_network);
			REG_BLOCK_NET:    prdata = DW'(cfg_q.block_network);
			default:          prdata = '0;
		endcase
	end
endmodule

@@ hdl/source_rate_monitor_ban_table.sv @@
// Per-source packet rate limiter with a ban table. A tick transfer advances the ms time
// and gives no result. A packet is worked by a sequencer that walks the tables one slot per
// cycle through a single compare unit: the ban table for expiry and ban lookup, then the
// count table for the count lookup, then an update step and a step that forms the first
// result. When a window closes within 1000 ms and auto ban is set, the count table is
// walked again, and the ban table is searched for each violator. Results leave one per
// transfer; no new item is taken until the last one is gone. A disabled packet skips the
// table walks. Configuration sits at byte addresses 8*i on a 64-bit apb port.
module source_rate_monitor_ban_table import srm_pkg::*; #(
	parameter int COUNT_SLOTS = DEF_COUNT_SLOTS,
	parameter int BAN_SLOTS   = DEF_BAN_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  req_t          req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rsp_t          rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [DW-1:0] pwdata,
	output logic [DW-1:0] prdata,
	output logic          pready
);
	localparam int CIW = (COUNT_SLOTS > 1) ? $clog2(COUNT_SLOTS) : 1;
	localparam int BIW = (BAN_SLOTS > 1) ? $clog2(BAN_SLOTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_EXPIRE, S_COUNT, S_UPDATE, S_CLOSE, S_BSRCH, S_FIRST, S_OUT
	} state_t;

	cfg_t cfg;

	srm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// tables
	logic [31:0] count_addr [COUNT_SLOTS];
	logic [15:0] count_value [COUNT_SLOTS];
	logic [31:0] ban_addr [BAN_SLOTS];
	logic [31:0] ban_time [BAN_SLOTS];
	logic [31:0] vbuf [MAX_VIOL];
	logic [COUNT_SLOTS-1:0] count_used_q;
	logic [BAN_SLOTS-1:0]   ban_used_q;

	state_t          state_q;
	logic [31:0]     now_q, wstart_q, src_q, vaddr_q;
	logic [15:0]     wcount_q;
	logic [25:0]     life_q;
	logic            en_q, hit_q, full_q, viol_q;
	logic [CIW-1:0]  cidx_q, fidx_q, cfree_idx_q;
	logic            found_q, cfree_q;
	logic [BIW-1:0]  bidx_q, bfree_idx_q;
	logic            bfree_q;
	logic [VCW-1:0]  vcnt_q, oidx_q;
	rsp_t            out_q;

	logic        accept, cidx_last, bidx_last;
	logic [31:0] c_addr, b_addr, b_time, v_rd;
	logic [15:0] c_val, wnext;
	logic        b_used, b_expired, c_cand, b_match;
	logic        b_free;
	logic [BIW-1:0] b_slot;
	logic        fast_close, count_new;
	logic        report;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = (state_q == S_OUT);
	assign rsp       = out_q;

	assign cidx_last = (cidx_q == CIW'(COUNT_SLOTS - 1));
	assign bidx_last = (bidx_q == BIW'(BAN_SLOTS - 1));
	assign c_addr    = count_addr[cidx_q];
	assign c_val     = count_value[cidx_q];
	assign b_addr    = ban_addr[bidx_q];
	assign b_time    = ban_time[bidx_q];
	assign b_used    = ban_used_q[bidx_q];
	assign v_rd      = vbuf[oidx_q[VIW-1:0]];
	assign b_expired = b_used && (cfg.ban_lifetime_s != 16'd0)
		&& ((now_q - b_time) > {6'd0, life_q});
	assign c_cand    = count_used_q[cidx_q] && (c_val >= cfg.source_limit)
		&& !net_match(cfg.allow_network, c_addr);
	assign b_match   = b_used && (b_addr == vaddr_q);
	// first free ban slot, the slot under the walk included
	assign b_free    = bfree_q || !b_used;
	assign b_slot    = bfree_q ? bfree_idx_q : bidx_q;
	assign wnext     = wcount_q + 16'd1;
	assign fast_close = ((now_q - wstart_q) <= WINDOW_MS);
	assign count_new  = !found_q && cfree_q;
	// a violator is stored: refreshed on a hit, or put into the first free slot
	assign report    = (state_q == S_BSRCH) && (b_match || (bidx_last && b_free));

	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE) begin
			if (found_q) begin
				if (count_value[fidx_q] != CNT_MAX)
					count_value[fidx_q] <= count_value[fidx_q] + 16'd1;
			end else if (cfree_q) begin
				count_addr[cfree_idx_q]  <= src_q;
				count_value[cfree_idx_q] <= 16'd1;
			end
		end
		if (state_q == S_BSRCH) begin
			if (b_match) begin
				ban_time[bidx_q] <= now_q;
			end else if (bidx_last && b_free) begin
				ban_addr[b_slot] <= vaddr_q;
				ban_time[b_slot] <= now_q;
			end
		end
		if (report && (vcnt_q < VCW'(MAX_VIOL)))
			vbuf[vcnt_q[VIW-1:0]] <= vaddr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			now_q        <= '0;
			wstart_q     <= '0;
			wcount_q     <= '0;
			count_used_q <= '0;
			ban_used_q   <= '0;
			src_q        <= '0;
			vaddr_q      <= '0;
			life_q       <= '0;
			en_q         <= 1'b0;
			hit_q        <= 1'b0;
			full_q       <= 1'b0;
			viol_q       <= 1'b0;
			cidx_q       <= '0;
			fidx_q       <= '0;
			cfree_idx_q  <= '0;
			found_q      <= 1'b0;
			cfree_q      <= 1'b0;
			bidx_q       <= '0;
			bfree_idx_q  <= '0;
			bfree_q      <= 1'b0;
			vcnt_q       <= '0;
			oidx_q       <= '0;
			out_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.func) begin
							now_q <= now_q + 32'd1;
						end else begin
							src_q   <= req.source_addr;
							en_q    <= cfg.enabled;
							life_q  <= 26'(cfg.ban_lifetime_s) * 26'd1000;
							hit_q   <= 1'b0;
							full_q  <= 1'b0;
							viol_q  <= 1'b0;
							found_q <= 1'b0;
							cfree_q <= 1'b0;
							bidx_q  <= '0;
							cidx_q  <= '0;
							vcnt_q  <= '0;
							state_q <= cfg.enabled ? S_EXPIRE : S_FIRST;
						end
					end
				end
				S_EXPIRE: begin
					if (b_expired)
						ban_used_q[bidx_q] <= 1'b0;
					if (b_used && !b_expired && (b_addr == src_q))
						hit_q <= 1'b1;
					if (bidx_last)
						state_q <= S_COUNT;
					else
						bidx_q <= bidx_q + BIW'(1);
				end
				S_COUNT: begin
					if (!found_q) begin
						if (count_used_q[cidx_q] && (c_addr == src_q)) begin
							found_q <= 1'b1;
							fidx_q  <= cidx_q;
						end else if (!count_used_q[cidx_q] && !cfree_q) begin
							cfree_q     <= 1'b1;
							cfree_idx_q <= cidx_q;
						end
					end
					if (cidx_last)
						state_q <= S_UPDATE;
					else
						cidx_q <= cidx_q + CIW'(1);
				end
				S_UPDATE: begin
					if (!found_q && !cfree_q)
						full_q <= 1'b1;
					cidx_q <= '0;
					if (wnext >= cfg.window_packet_limit) begin
						wcount_q <= '0;
						viol_q   <= fast_close;
						if (fast_close && cfg.auto_ban) begin
							if (count_new)
								count_used_q[cfree_idx_q] <= 1'b1;
							state_q <= S_CLOSE;
						end else begin
							count_used_q <= '0;
							wstart_q     <= now_q;
							state_q      <= S_FIRST;
						end
					end else begin
						if (count_new)
							count_used_q[cfree_idx_q] <= 1'b1;
						wcount_q <= wnext;
						state_q  <= S_FIRST;
					end
				end
				S_CLOSE: begin
					if (c_cand) begin
						vaddr_q <= c_addr;
						bidx_q  <= '0;
						bfree_q <= 1'b0;
						state_q <= S_BSRCH;
					end else if (cidx_last) begin
						count_used_q <= '0;
						wstart_q     <= now_q;
						state_q      <= S_FIRST;
					end else begin
						cidx_q <= cidx_q + CIW'(1);
					end
				end
				S_BSRCH: begin
					if (report && (vcnt_q < VCW'(MAX_VIOL)))
						vcnt_q <= vcnt_q + VCW'(1);
					if (!b_match && !b_used && !bfree_q) begin
						bfree_q     <= 1'b1;
						bfree_idx_q <= bidx_q;
					end
					if (!b_match && bidx_last) begin
						if (b_free)
							ban_used_q[b_slot] <= 1'b1;
						else
							full_q <= 1'b1;
					end
					if (b_match || bidx_last) begin
						if (cidx_last) begin
							count_used_q <= '0;
							wstart_q     <= now_q;
							state_q      <= S_FIRST;
						end else begin
							cidx_q  <= cidx_q + CIW'(1);
							state_q <= S_CLOSE;
						end
					end else begin
						bidx_q <= bidx_q + BIW'(1);
					end
				end
				S_FIRST: begin
					out_q.banned <= en_q && !net_match(cfg.allow_network, src_q)
						&& (cfg.deny_all || hit_q || net_match(cfg.block_network, src_q));
					out_q.threshold_violated <= viol_q;
					out_q.violator_valid     <= 1'b0;
					out_q.violator_addr      <= '0;
					out_q.table_full         <= full_q;
					out_q.last               <= (vcnt_q == '0);
					oidx_q  <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp_ready) begin
						if (oidx_q < vcnt_q) begin
							out_q.banned             <= 1'b0;
							out_q.threshold_violated <= 1'b0;
							out_q.violator_valid     <= 1'b1;
							out_q.violator_addr      <= v_rd;
							out_q.table_full         <= 1'b0;
							out_q.last               <= ((oidx_q + VCW'(1)) == vcnt_q);
							oidx_q <= oidx_q + VCW'(1);
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("input taken while results pending");
	a_vcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= VCW'(MAX_VIOL)) else $error("violator count overflow");
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && rsp.last) |=> req_ready)
		else $error("block not idle after last result");
	a_viol_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.violator_valid) |-> (!rsp.banned && !rsp.table_full))
		else $error("violator result carries first-result flags");
`endif
endmodule
